@@ design/paged_bus_bridge_translator_core_macros.svh @@
// Assertion helpers shared by the bridge RTL.
`ifndef PAGED_BUS_BRIDGE_TRANSLATOR_CORE_MACROS_SVH
`define PAGED_BUS_BRIDGE_TRANSLATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBBT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bridge assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PBBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bridge assertion failed");

`endif

@@ design/pbbt_pkg.sv @@
`timescale 1ns / 1ps

package pbbt_pkg;

   localparam int ADDR_W   = 20;
   localparam int WORD_W   = 36;
   localparam int HALF_W   = 16;
   localparam int BUS_W    = 3;
   localparam int OFFSET_W = 10;
   localparam int PAGE_W   = 8;

   // Host function codes.
   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_REPLY = 2'd2;

   // Result item kinds.
   localparam logic [1:0] KIND_RREQ = 2'd0;
   localparam logic [1:0] KIND_WREQ = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;

   // The top ten address bits all set select the control page.
   localparam logic [ADDR_W-1:0]   CTRL_PAGE_BASE = 20'hFFC00;
   localparam logic [OFFSET_W-1:0] CTRL_OFFSET_LIMIT = 10'o400;

   // Page entry layout.
   localparam int ENT_VALID_BIT = 35;
   localparam int ENT_BUS_LSB   = 26;
   localparam int ENT_BASE_LSB  = 10;

   // Write mask bits in the host word.
   localparam int WMASK_FIRST_BIT  = 3;
   localparam int WMASK_SECOND_BIT = 2;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_FIRST,
      PHASE_SECOND
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EMIT
   } seq_state_type;

   typedef struct packed {
      logic [1:0]          item_kind;
      logic [BUS_W-1:0]    bus_number;
      logic [ADDR_W-1:0]   bus_address;
      logic [HALF_W-1:0]   bus_data;
      logic [WORD_W-1:0]   read_value;
      logic                fault;
      logic                last;
   } rsp_item_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } tbl_cmd_type;

endpackage

@@ design/pbbt_if.sv @@
`timescale 1ns / 1ps

interface pbbt_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    func;
   logic [pbbt_pkg::ADDR_W-1:0]   access_address;
   logic [pbbt_pkg::WORD_W-1:0]   write_value;
   logic [pbbt_pkg::HALF_W-1:0]   reply_word;

   modport source (output valid, func, access_address, write_value, reply_word,
                   input ready);
   modport sink (input valid, func, access_address, write_value, reply_word,
                 output ready);
endinterface

interface pbbt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    item_kind;
   logic [pbbt_pkg::BUS_W-1:0]    bus_number;
   logic [pbbt_pkg::ADDR_W-1:0]   bus_address;
   logic [pbbt_pkg::HALF_W-1:0]   bus_data;
   logic [pbbt_pkg::WORD_W-1:0]   read_value;
   logic                          fault;
   logic                          last;

   modport source (output valid, item_kind, bus_number, bus_address, bus_data,
                   read_value, fault, last, input ready);
   modport sink (input valid, item_kind, bus_number, bus_address, bus_data,
                 read_value, fault, last, output ready);
endinterface

@@ design/paged_bus_bridge_translator_core.sv @@
`timescale 1ns / 1ps
// Channel      Direction  Beat carries
// req_chan     in         func, access_address, write_value, reply_word
// rsp_chan     out        item_kind, bus_number, bus_address, bus_data,
//                         read_value, fault, last
//
// A host access through the page table goes through accept, the table read
// and the result beats one at a time: up to two bus writes and a completion
// for a write, one beat for a read, a control-page read or an entry fault. A
// bus reply, a control-page write or a fault found before the table read skips
// the table read. Reset clears the entry valid flags, so beats are accepted
// from the first cycle after reset; a stall on rsp_chan holds the sequencer in
// its emit step until the final beat of an access sits in the output register.

`include "paged_bus_bridge_translator_core_macros.svh"

module paged_bus_bridge_translator_core #(
   parameter int PAGE_ENTRIES = 256
) (
   input  logic       clock,
   input  logic       reset,
   pbbt_req_if.sink   req_chan,
   pbbt_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(PAGE_ENTRIES);

   // Sequencer to page table.
   pbbt_pkg::tbl_cmd_type          tbl_cmd;
   logic [IDX_W-1:0]               tbl_index;
   logic [pbbt_pkg::WORD_W-1:0]    tbl_wr_data;
   logic [pbbt_pkg::WORD_W-1:0]    tbl_rd_data;

   // Sequencer to output register.
   logic                           out_valid;
   pbbt_pkg::rsp_item_type         out_item;
   logic                           out_take;

   // The output register parts the result side from the sequencer, so a
   // held final result beat does not block a new request beat.
   logic                           rsp_valid_ff, rsp_valid_in;
   pbbt_pkg::rsp_item_type         rsp_item_ff, rsp_item_in;
   logic                           slot_free;

   // Beat qualifiers used by the checks at the end of the module.
   logic                           host_beat_taken;
   logic                           rsp_done_beat;
   logic                           rsp_wreq_beat;

   pbbt_table #(
      .PAGE_ENTRIES (PAGE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .cmd     (tbl_cmd),
      .index   (tbl_index),
      .wr_data (tbl_wr_data),
      .rd_data (tbl_rd_data)
   );

   pbbt_seq #(
      .PAGE_ENTRIES (PAGE_ENTRIES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .out_valid   (out_valid),
      .out_item    (out_item),
      .out_take    (out_take),
      .tbl_cmd     (tbl_cmd),
      .tbl_index   (tbl_index),
      .tbl_wr_data (tbl_wr_data),
      .tbl_rd_data (tbl_rd_data)
   );

   // The register may be reloaded in the same cycle that its beat is taken.
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign out_take  = out_valid && slot_free;

   always_comb begin
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_take) begin
         rsp_item_in  = out_item;
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.item_kind   = rsp_item_ff.item_kind;
   assign rsp_chan.bus_number  = rsp_item_ff.bus_number;
   assign rsp_chan.bus_address = rsp_item_ff.bus_address;
   assign rsp_chan.bus_data    = rsp_item_ff.bus_data;
   assign rsp_chan.read_value  = rsp_item_ff.read_value;
   assign rsp_chan.fault       = rsp_item_ff.fault;
   assign rsp_chan.last        = rsp_item_ff.last;

   assign host_beat_taken = req_chan.valid && req_chan.ready
                         && (req_chan.func == pbbt_pkg::FUNC_READ
                             || req_chan.func == pbbt_pkg::FUNC_WRITE);
   assign rsp_done_beat   = rsp_chan.valid && (rsp_chan.item_kind == pbbt_pkg::KIND_DONE);
   assign rsp_wreq_beat   = rsp_chan.valid && (rsp_chan.item_kind == pbbt_pkg::KIND_WREQ);

   // A completion always closes the group of beats for its access.
   `PBBT_ASSERT_IMP(a_done_is_last, clock, reset, rsp_done_beat, rsp_chan.last)

   // A bus write is always followed by at least the completion.
   `PBBT_ASSERT_IMP(a_write_not_last, clock, reset, rsp_wreq_beat, !rsp_chan.last)

   // Faults are only reported on completions.
   `PBBT_ASSERT_IMP(a_fault_on_done, clock, reset, rsp_chan.valid && rsp_chan.fault, rsp_done_beat)

   // A host access always occupies the sequencer for at least the next cycle.
   `PBBT_ASSERT_NEXT(a_access_blocks, clock, reset, host_beat_taken, !req_chan.ready)

endmodule

@@ design/pbbt_table.sv @@
`timescale 1ns / 1ps

// Page table: one synchronous memory plus a valid flag per entry, so that an
// entry never written reads as zero.
module pbbt_table #(
   parameter int PAGE_ENTRIES = 256,
   localparam int IDX_W = $clog2(PAGE_ENTRIES)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pbbt_pkg::tbl_cmd_type         cmd,
   input  logic [IDX_W-1:0]              index,
   input  logic [pbbt_pkg::WORD_W-1:0]   wr_data,
   output logic [pbbt_pkg::WORD_W-1:0]   rd_data
);

   logic [pbbt_pkg::WORD_W-1:0] page_mem [PAGE_ENTRIES];
   logic [PAGE_ENTRIES-1:0]     valid_ff;
   logic [PAGE_ENTRIES-1:0]     valid_in;
   logic [pbbt_pkg::WORD_W-1:0] rd_word_ff;
   logic                        rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.wr_en) begin
         valid_in[index] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         page_mem[index] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_word_ff  <= page_mem[index];
         rd_valid_ff <= valid_ff[index];
      end
   end

   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

@@ design/pbbt_seq.sv @@
`timescale 1ns / 1ps

// Access sequencer: decodes host beats, drives the page table, checks the
// entry and steps through the result beats one at a time.
module pbbt_seq #(
   parameter int PAGE_ENTRIES = 256,
   localparam int IDX_W = $clog2(PAGE_ENTRIES)
) (
   input  logic                          clock,
   input  logic                          reset,
   pbbt_req_if.sink                      req_chan,
   output logic                          out_valid,
   output pbbt_pkg::rsp_item_type        out_item,
   input  logic                          out_take,
   output pbbt_pkg::tbl_cmd_type         tbl_cmd,
   output logic [IDX_W-1:0]              tbl_index,
   output logic [pbbt_pkg::WORD_W-1:0]   tbl_wr_data,
   input  logic [pbbt_pkg::WORD_W-1:0]   tbl_rd_data
);

   function automatic pbbt_pkg::rsp_item_type make_done(
      input logic [pbbt_pkg::WORD_W-1:0] value,
      input logic                        flt
   );
      pbbt_pkg::rsp_item_type item;
      item            = '0;
      item.item_kind  = pbbt_pkg::KIND_DONE;
      item.read_value = value;
      item.fault      = flt;
      item.last       = 1'b1;
      return item;
   endfunction

   function automatic pbbt_pkg::rsp_item_type make_rreq(
      input logic [pbbt_pkg::BUS_W-1:0]  bus,
      input logic [pbbt_pkg::ADDR_W-1:0] addr
   );
      pbbt_pkg::rsp_item_type item;
      item             = '0;
      item.item_kind   = pbbt_pkg::KIND_RREQ;
      item.bus_number  = bus;
      item.bus_address = addr;
      item.last        = 1'b1;
      return item;
   endfunction

   pbbt_pkg::seq_state_type         state_ff, state_in;
   pbbt_pkg::phase_type             phase_ff, phase_in;
   logic [pbbt_pkg::ADDR_W-1:0]     pend_addr_ff, pend_addr_in;
   logic [pbbt_pkg::BUS_W-1:0]      pend_bus_ff, pend_bus_in;
   logic [pbbt_pkg::HALF_W-1:0]     upper_ff, upper_in;
   logic                            todo_w0_ff, todo_w0_in;
   logic                            todo_w1_ff, todo_w1_in;
   logic                            is_ctrl_ff, is_ctrl_in;
   logic                            is_write_ff, is_write_in;
   logic [pbbt_pkg::OFFSET_W-1:0]   offset_ff, offset_in;
   logic [pbbt_pkg::WORD_W-1:0]     wv_ff, wv_in;
   logic [pbbt_pkg::BUS_W-1:0]      bus_ff, bus_in;
   logic [pbbt_pkg::ADDR_W-1:0]     baddr_ff, baddr_in;
   pbbt_pkg::rsp_item_type          final_ff, final_in;

   logic                            accept;
   logic                            req_ctrl;
   logic [pbbt_pkg::OFFSET_W-1:0]   req_offset;
   logic [pbbt_pkg::PAGE_W-1:0]     req_page;
   logic                            ctrl_offset_ok;
   logic                            page_ok;
   logic                            ent_ok;
   logic [pbbt_pkg::ADDR_W-3:0]     word_sum;
   logic [pbbt_pkg::ADDR_W-1:0]     lookup_baddr;
   logic [pbbt_pkg::BUS_W-1:0]      lookup_bus;

   assign req_chan.ready = (state_ff == pbbt_pkg::ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   assign req_ctrl   = (req_chan.access_address >= pbbt_pkg::CTRL_PAGE_BASE);
   assign req_offset = req_chan.access_address[pbbt_pkg::OFFSET_W-1:0];
   assign req_page   = req_chan.access_address[pbbt_pkg::OFFSET_W +: pbbt_pkg::PAGE_W];
   assign ctrl_offset_ok = (req_offset < pbbt_pkg::CTRL_OFFSET_LIMIT)
                        && ({1'b0, req_offset} < (pbbt_pkg::OFFSET_W + 1)'(PAGE_ENTRIES));
   assign page_ok = ({1'b0, req_page} < (pbbt_pkg::PAGE_W + 1)'(PAGE_ENTRIES));

   // Entry check and address formation on the registered table word.
   assign ent_ok = tbl_rd_data[pbbt_pkg::ENT_VALID_BIT]
                && (offset_ff <= tbl_rd_data[pbbt_pkg::OFFSET_W-1:0]);
   assign lookup_bus = tbl_rd_data[pbbt_pkg::ENT_BUS_LSB +: pbbt_pkg::BUS_W];
   assign word_sum   = (pbbt_pkg::ADDR_W - 2)'(tbl_rd_data[pbbt_pkg::ENT_BASE_LSB +:
                                                          pbbt_pkg::HALF_W])
                     + (pbbt_pkg::ADDR_W - 2)'(offset_ff);
   assign lookup_baddr = {word_sum, 2'b00};

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pend_addr_in = pend_addr_ff;
      pend_bus_in  = pend_bus_ff;
      upper_in     = upper_ff;
      todo_w0_in   = todo_w0_ff;
      todo_w1_in   = todo_w1_ff;
      is_ctrl_in   = is_ctrl_ff;
      is_write_in  = is_write_ff;
      offset_in    = offset_ff;
      wv_in        = wv_ff;
      bus_in       = bus_ff;
      baddr_in     = baddr_ff;
      final_in     = final_ff;
      tbl_cmd      = '0;
      tbl_index    = req_ctrl ? req_offset[IDX_W-1:0] : req_page[IDX_W-1:0];
      tbl_wr_data  = req_chan.write_value;
      out_valid    = 1'b0;
      out_item     = final_ff;

      case (state_ff)
         pbbt_pkg::ST_IDLE: begin
            if (accept) begin
               is_ctrl_in  = req_ctrl;
               is_write_in = (req_chan.func == pbbt_pkg::FUNC_WRITE);
               offset_in   = req_offset;
               wv_in       = req_chan.write_value;
               todo_w0_in  = 1'b0;
               todo_w1_in  = 1'b0;
               case (req_chan.func)
                  pbbt_pkg::FUNC_REPLY: begin
                     case (phase_ff)
                        pbbt_pkg::PHASE_FIRST: begin
                           upper_in = req_chan.reply_word;
                           phase_in = pbbt_pkg::PHASE_SECOND;
                           final_in = make_rreq(pend_bus_ff,
                                                pbbt_pkg::ADDR_W'(pend_addr_ff + 2'd2));
                           state_in = pbbt_pkg::ST_EMIT;
                        end
                        pbbt_pkg::PHASE_SECOND: begin
                           phase_in = pbbt_pkg::PHASE_IDLE;
                           final_in = make_done({upper_ff, req_chan.reply_word, 4'b0000},
                                                1'b0);
                           state_in = pbbt_pkg::ST_EMIT;
                        end
                        default: begin
                        end
                     endcase
                  end
                  pbbt_pkg::FUNC_READ, pbbt_pkg::FUNC_WRITE: begin
                     phase_in = pbbt_pkg::PHASE_IDLE;
                     if (req_ctrl) begin
                        if (!ctrl_offset_ok) begin
                           final_in = make_done('0, 1'b1);
                           state_in = pbbt_pkg::ST_EMIT;
                        end else if (req_chan.func == pbbt_pkg::FUNC_WRITE) begin
                           tbl_cmd.wr_en = 1'b1;
                           final_in      = make_done('0, 1'b0);
                           state_in      = pbbt_pkg::ST_EMIT;
                        end else begin
                           tbl_cmd.rd_en = 1'b1;
                           state_in      = pbbt_pkg::ST_LOOKUP;
                        end
                     end else if (!page_ok) begin
                        final_in = make_done('0, 1'b1);
                        state_in = pbbt_pkg::ST_EMIT;
                     end else begin
                        tbl_cmd.rd_en = 1'b1;
                        state_in      = pbbt_pkg::ST_LOOKUP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         pbbt_pkg::ST_LOOKUP: begin
            state_in = pbbt_pkg::ST_EMIT;
            if (is_ctrl_ff) begin
               final_in = make_done(tbl_rd_data, 1'b0);
            end else if (!ent_ok) begin
               final_in = make_done('0, 1'b1);
            end else if (!is_write_ff) begin
               pend_addr_in = lookup_baddr;
               pend_bus_in  = lookup_bus;
               phase_in     = pbbt_pkg::PHASE_FIRST;
               final_in     = make_rreq(lookup_bus, lookup_baddr);
            end else begin
               bus_in     = lookup_bus;
               baddr_in   = lookup_baddr;
               todo_w0_in = !wv_ff[pbbt_pkg::WMASK_FIRST_BIT];
               todo_w1_in = !wv_ff[pbbt_pkg::WMASK_SECOND_BIT];
               final_in   = make_done('0, 1'b0);
            end
         end
         pbbt_pkg::ST_EMIT: begin
            out_valid = 1'b1;
            if (todo_w0_ff || todo_w1_ff) begin
               out_item            = '0;
               out_item.item_kind  = pbbt_pkg::KIND_WREQ;
               out_item.bus_number = bus_ff;
               if (todo_w0_ff) begin
                  out_item.bus_address = baddr_ff;
                  out_item.bus_data    = wv_ff[pbbt_pkg::WORD_W-1 -: pbbt_pkg::HALF_W];
               end else begin
                  out_item.bus_address = pbbt_pkg::ADDR_W'(baddr_ff + 2'd2);
                  out_item.bus_data    = wv_ff[4 +: pbbt_pkg::HALF_W];
               end
            end
            if (out_take) begin
               if (todo_w0_ff) begin
                  todo_w0_in = 1'b0;
               end else if (todo_w1_ff) begin
                  todo_w1_in = 1'b0;
               end else begin
                  state_in = pbbt_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = pbbt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbbt_pkg::ST_IDLE;
         phase_ff     <= pbbt_pkg::PHASE_IDLE;
         pend_addr_ff <= '0;
         pend_bus_ff  <= '0;
         upper_ff     <= '0;
         todo_w0_ff   <= 1'b0;
         todo_w1_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pend_addr_ff <= pend_addr_in;
         pend_bus_ff  <= pend_bus_in;
         upper_ff     <= upper_in;
         todo_w0_ff   <= todo_w0_in;
         todo_w1_ff   <= todo_w1_in;
      end
   end

   always_ff @(posedge clock) begin
      is_ctrl_ff  <= is_ctrl_in;
      is_write_ff <= is_write_in;
      offset_ff   <= offset_in;
      wv_ff       <= wv_in;
      bus_ff      <= bus_in;
      baddr_ff    <= baddr_in;
      final_ff    <= final_in;
   end

endmodule
